[rtl/core/hid2ps2_pkg.sv]
package hid2ps2_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int MOD_BITS  = 8;
   localparam int NUM_EVENTS = MOD_BITS + 2 * KEY_SLOTS;
   localparam int EV_W  = $clog2(NUM_EVENTS + 1);
   localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   localparam logic [7:0] BREAK_PREFIX   = 8'hF0;
   localparam logic [7:0] EXT_PREFIX     = 8'hE0;
   localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
   localparam logic [7:0] MOD_USAGE_LAST = 8'hE7;
   localparam logic [7:0] MAIN_USAGE_END = 8'h90;
   localparam logic [7:0] ROLLOVER_LO    = 8'h01;
   localparam logic [7:0] ROLLOVER_HI    = 8'h03;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] key_slot_0;
      logic [7:0] key_slot_1;
      logic [7:0] key_slot_2;
      logic [7:0] key_slot_3;
      logic [7:0] key_slot_4;
      logic [7:0] key_slot_5;
   } req_type;

   typedef struct packed {
      logic [7:0] scan_byte;
      logic       byte_valid;
      logic       last_of_report;
      logic [7:0] held_key;
      logic       repeat_restart;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic analyze;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic out_free;
   } status_type;

   localparam logic [15:0] MAIN_CODES [0:143] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001C, 16'h0032, 16'h0021, 16'h0023,
      16'h0024, 16'h002B, 16'h0034, 16'h0033, 16'h0043, 16'h003B, 16'h0042, 16'h004B,
      16'h003A, 16'h0031, 16'h0044, 16'h004D, 16'h0015, 16'h002D, 16'h001B, 16'h002C,
      16'h003C, 16'h002A, 16'h001D, 16'h0022, 16'h0035, 16'h001A, 16'h0016, 16'h001E,
      16'h0026, 16'h0025, 16'h002E, 16'h0036, 16'h003D, 16'h003E, 16'h0046, 16'h0045,
      16'h005A, 16'h0076, 16'h0066, 16'h000D, 16'h0029, 16'h004E, 16'h0055, 16'h0054,
      16'h005B, 16'h005D, 16'h005D, 16'h004C, 16'h0052, 16'h000E, 16'h0041, 16'h0049,
      16'h004A, 16'h0058, 16'h0005, 16'h0006, 16'h0004, 16'h000C, 16'h0003, 16'h000B,
      16'h0083, 16'h000A, 16'h0001, 16'h0009, 16'h0078, 16'h0007, 16'h0000, 16'h007E,
      16'h0000, 16'hE070, 16'hE06C, 16'hE07D, 16'hE071, 16'hE069, 16'hE07A, 16'hE074,
      16'hE06B, 16'hE072, 16'hE075, 16'h0077, 16'hE04A, 16'h007C, 16'h007B, 16'h0079,
      16'hE05A, 16'h0069, 16'h0072, 16'h007A, 16'h006B, 16'h0073, 16'h0074, 16'h006C,
      16'h0075, 16'h007D, 16'h0070, 16'h0071, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0051,
      16'h0013, 16'h006A, 16'h0064, 16'h0067, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   localparam logic [15:0] MOD_CODES [0:7] = '{
      16'h0014, 16'h0012, 16'h0011, 16'h0000, 16'hE014, 16'h0059, 16'hE011, 16'h0000
   };

   // set-2 code for a usage, zero when the usage has none
   function automatic logic [15:0] code_of(input logic [7:0] usage);
      logic [15:0] code;
      code = 16'h0000;
      if (usage < MAIN_USAGE_END) begin
         code = MAIN_CODES[usage];
      end else if (usage >= MOD_USAGE_BASE && usage <= MOD_USAGE_LAST) begin
         code = MOD_CODES[usage[2:0]];
      end
      return code;
   endfunction

endpackage

[rtl/core/usb_hid_report_to_ps2_scancodes_core.sv]
// Translates USB boot-keyboard reports into PS/2 set-2 scan code words. One report
// is taken when the block is idle; it is then captured and compared against the
// stored key list, and the single event walker goes over 8 modifier events plus 6
// break and 6 make events, sending the words of each event in turn, before a final
// flush step sends the last word. The walk is held when the result side stalls, and
// a report gives at most 44 words in the worst case. Every word carries the held key
// and repeat-restart flag of the whole report; a report that sends nothing gives one
// word with byte_valid low. Results wait in an output register, so the next report
// is accepted while the last word is still pending.
module usb_hid_report_to_ps2_scancodes_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hid2ps2_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hid2ps2_pkg::rsp_type rsp_data
);

   hid2ps2_pkg::cmd_type    cmd;
   hid2ps2_pkg::status_type status;

   hid2ps2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hid2ps2_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/hid2ps2_ctrl.sv]
module hid2ps2_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  hid2ps2_pkg::status_type status,
   output hid2ps2_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_ANALYZE = 4'b0010,
      ST_WALK    = 4'b0100,
      ST_FLUSH   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ANALYZE;
            end
         end
         ST_ANALYZE: begin
            cmd.analyze = 1'b1;
            state_in    = ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_flush_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> status.out_free) else $error("flush without output room");
   a_analyze_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.analyze) else $error("analyze did not follow load");
   a_walk_after_analyze: assert property (@(posedge clock) disable iff (reset)
      cmd.analyze |=> (state_ff == ST_WALK)) else $error("walk did not follow analyze");
`endif

endmodule

[rtl/core/hid2ps2_dp.sv]
module hid2ps2_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  hid2ps2_pkg::req_type    req_data,
   input  hid2ps2_pkg::cmd_type    cmd,
   output hid2ps2_pkg::status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output hid2ps2_pkg::rsp_type    rsp_data
);

   localparam int K     = hid2ps2_pkg::KEY_SLOTS;
   localparam int EV_W  = hid2ps2_pkg::EV_W;
   localparam int IDX_W = hid2ps2_pkg::IDX_W;

   logic [7:0] mods_ff;
   logic [7:0] slots_ff     [K];
   logic [7:0] prev_mod_ff;
   logic [7:0] prev_keys_ff [K];
   logic [7:0] held_ff,   held_in;
   logic       restart_ff, restart_in;
   logic [K-1:0] gone_ff, gone_in;
   logic [K-1:0] fresh_ff, fresh_in;
   logic       roll_ff, roll_in;
   logic [EV_W-1:0] ev_ff;
   logic [1:0] sub_ff;
   logic [7:0] pend_ff;
   logic       pend_vld_ff;
   hid2ps2_pkg::rsp_type out_ff;
   logic       out_vld_ff;

   // analysis of the captured report against the stored key list
   always_comb begin
      logic held_gone;
      roll_in    = 1'b0;
      held_gone  = 1'b0;
      held_in    = held_ff;
      restart_in = 1'b0;
      for (int i = 0; i < K; i++) begin
         if (slots_ff[i] >= hid2ps2_pkg::ROLLOVER_LO &&
             slots_ff[i] <= hid2ps2_pkg::ROLLOVER_HI) begin
            roll_in = 1'b1;
         end
      end
      for (int i = 0; i < K; i++) begin
         logic seen;
         seen = 1'b0;
         for (int j = 0; j < K; j++) begin
            if (prev_keys_ff[i] == slots_ff[j]) seen = 1'b1;
         end
         gone_in[i] = (prev_keys_ff[i] != 8'h00) && !seen;
         if (gone_in[i] && prev_keys_ff[i] == held_ff) held_gone = 1'b1;
      end
      for (int i = 0; i < K; i++) begin
         logic known;
         known = 1'b0;
         for (int j = 0; j < K; j++) begin
            if (prev_keys_ff[j] != 8'h00 && prev_keys_ff[j] == slots_ff[i]) known = 1'b1;
         end
         fresh_in[i] = (slots_ff[i] != 8'h00) && !known;
      end
      if (!roll_in) begin
         if (held_gone) held_in = 8'h00;
         for (int i = 0; i < K; i++) begin
            if (fresh_in[i]) held_in = slots_ff[i];
         end
         restart_in = |fresh_in;
      end
   end

   // event decode: modifier bits, then breaks over the stored list, then makes
   logic [EV_W-1:0]  off_brk, off_mk;
   logic [IDX_W-1:0] idx_brk, idx_mk;
   logic [7:0]  usage;
   logic        is_break, active;
   logic [15:0] code;
   logic        ext, emit_ok;
   logic [1:0]  last_sub;
   logic [7:0]  byte_sel;

   assign off_brk = ev_ff - EV_W'(hid2ps2_pkg::MOD_BITS);
   assign off_mk  = ev_ff - EV_W'(hid2ps2_pkg::MOD_BITS + K);
   assign idx_brk = off_brk[IDX_W-1:0];
   assign idx_mk  = off_mk[IDX_W-1:0];

   always_comb begin
      if (ev_ff < EV_W'(hid2ps2_pkg::MOD_BITS)) begin
         usage    = hid2ps2_pkg::MOD_USAGE_BASE | {5'b00000, ev_ff[2:0]};
         is_break = !mods_ff[ev_ff[2:0]];
         active   = mods_ff[ev_ff[2:0]] ^ prev_mod_ff[ev_ff[2:0]];
      end else if (ev_ff < EV_W'(hid2ps2_pkg::MOD_BITS + K)) begin
         usage    = prev_keys_ff[idx_brk];
         is_break = 1'b1;
         active   = !roll_ff && gone_ff[idx_brk];
      end else begin
         usage    = slots_ff[idx_mk];
         is_break = 1'b0;
         active   = !roll_ff && fresh_ff[idx_mk];
      end
   end

   assign code     = hid2ps2_pkg::code_of(usage);
   assign ext      = code[15:8] != 8'h00;
   assign emit_ok  = active && (code != 16'h0000);
   assign last_sub = {1'b0, ext} + {1'b0, is_break};

   always_comb begin
      byte_sel = code[7:0];
      case (sub_ff)
         2'd0: begin
            if (ext)           byte_sel = hid2ps2_pkg::EXT_PREFIX;
            else if (is_break) byte_sel = hid2ps2_pkg::BREAK_PREFIX;
         end
         2'd1: begin
            if (ext && is_break) byte_sel = hid2ps2_pkg::BREAK_PREFIX;
         end
         default: byte_sel = code[7:0];
      endcase
   end

   logic out_free, stall, step_go, emit, push_mid;

   assign out_free = !out_vld_ff || rsp_ready;
   assign stall    = emit_ok && pend_vld_ff && !out_free;
   assign step_go  = cmd.step && !stall;
   assign emit     = step_go && emit_ok;
   assign push_mid = emit && pend_vld_ff;

   assign status.walk_done = ev_ff == EV_W'(hid2ps2_pkg::NUM_EVENTS);
   assign status.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mods_ff     <= req_data.modifier_bits;
         slots_ff[0] <= req_data.key_slot_0;
         slots_ff[1] <= req_data.key_slot_1;
         slots_ff[2] <= req_data.key_slot_2;
         slots_ff[3] <= req_data.key_slot_3;
         slots_ff[4] <= req_data.key_slot_4;
         slots_ff[5] <= req_data.key_slot_5;
      end
      if (cmd.analyze) begin
         gone_ff  <= gone_in;
         fresh_ff <= fresh_in;
         roll_ff  <= roll_in;
      end
      if (emit) begin
         pend_ff <= byte_sel;
      end
      if (push_mid) begin
         out_ff <= '{scan_byte: pend_ff, byte_valid: 1'b1, last_of_report: 1'b0,
                     held_key: held_ff, repeat_restart: restart_ff};
      end else if (cmd.flush) begin
         out_ff <= '{scan_byte: pend_vld_ff ? pend_ff : 8'h00, byte_valid: pend_vld_ff,
                     last_of_report: 1'b1, held_key: held_ff,
                     repeat_restart: restart_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mod_ff <= '0;
         for (int i = 0; i < K; i++) prev_keys_ff[i] <= '0;
         held_ff     <= '0;
         restart_ff  <= 1'b0;
         ev_ff       <= '0;
         sub_ff      <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (cmd.analyze) begin
            held_ff    <= held_in;
            restart_ff <= restart_in;
            ev_ff      <= '0;
            sub_ff     <= '0;
         end else if (step_go) begin
            if (emit && sub_ff != last_sub) begin
               sub_ff <= sub_ff + 2'd1;
            end else begin
               sub_ff <= '0;
               ev_ff  <= ev_ff + EV_W'(1);
            end
         end
         if (emit) begin
            pend_vld_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_vld_ff <= 1'b0;
         end
         if (push_mid || cmd.flush) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
         // stored modifiers and key list move on only once the whole report is walked; the key list stays on rollover
         if (cmd.flush) begin
            prev_mod_ff <= mods_ff;
            if (!roll_ff) begin
               for (int i = 0; i < K; i++) prev_keys_ff[i] <= slots_ff[i];
            end
         end
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_mid |-> out_free) else $error("word pushed over a waiting result");
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ev_ff <= EV_W'(hid2ps2_pkg::NUM_EVENTS)) else $error("event cursor out of range");
   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'd3) else $error("byte index out of range");
   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (!pend_vld_ff && out_vld_ff && rsp_data.last_of_report))
      else $error("flush left a pending byte");
`endif

endmodule

[tb/usb_hid_report_to_ps2_scancodes_core_tb.sv]
`timescale 1ns / 1ps

module usb_hid_report_to_ps2_scancodes_core_tb;

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 11;
   localparam int IDLE_PCT        = 37;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 80;

   localparam logic [7:0] SET2_BREAK  = 8'hF0;
   localparam logic [7:0] MOD_USAGE0  = 8'hE0;
   localparam logic [7:0] MAIN_END    = 8'h90;
   localparam logic [7:0] ROLLOVER_LO = 8'h01;
   localparam logic [7:0] ROLLOVER_HI = 8'h03;

   localparam logic [15:0] SET2_MAIN [0:143] = '{
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h001C, 16'h0032, 16'h0021, 16'h0023,
      16'h0024, 16'h002B, 16'h0034, 16'h0033, 16'h0043, 16'h003B, 16'h0042, 16'h004B,
      16'h003A, 16'h0031, 16'h0044, 16'h004D, 16'h0015, 16'h002D, 16'h001B, 16'h002C,
      16'h003C, 16'h002A, 16'h001D, 16'h0022, 16'h0035, 16'h001A, 16'h0016, 16'h001E,
      16'h0026, 16'h0025, 16'h002E, 16'h0036, 16'h003D, 16'h003E, 16'h0046, 16'h0045,
      16'h005A, 16'h0076, 16'h0066, 16'h000D, 16'h0029, 16'h004E, 16'h0055, 16'h0054,
      16'h005B, 16'h005D, 16'h005D, 16'h004C, 16'h0052, 16'h000E, 16'h0041, 16'h0049,
      16'h004A, 16'h0058, 16'h0005, 16'h0006, 16'h0004, 16'h000C, 16'h0003, 16'h000B,
      16'h0083, 16'h000A, 16'h0001, 16'h0009, 16'h0078, 16'h0007, 16'h0000, 16'h007E,
      16'h0000, 16'hE070, 16'hE06C, 16'hE07D, 16'hE071, 16'hE069, 16'hE07A, 16'hE074,
      16'hE06B, 16'hE072, 16'hE075, 16'h0077, 16'hE04A, 16'h007C, 16'h007B, 16'h0079,
      16'hE05A, 16'h0069, 16'h0072, 16'h007A, 16'h006B, 16'h0073, 16'h0074, 16'h006C,
      16'h0075, 16'h007D, 16'h0070, 16'h0071, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0051,
      16'h0013, 16'h006A, 16'h0064, 16'h0067, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

   localparam logic [15:0] SET2_MOD [0:7] = '{
      16'h0014, 16'h0012, 16'h0011, 16'h0000, 16'hE014, 16'h0059, 16'hE011, 16'h0000
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   hid2ps2_pkg::req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   hid2ps2_pkg::rsp_type rsp_data;

   // translator state as seen from outside
   logic [7:0] last_mods;
   logic [7:0] down_keys [6];
   logic [7:0] held_key_state;
   logic [7:0] scan_bytes [$];
   hid2ps2_pkg::rsp_type expected_words [$];

   // virtual keyboard driving the typing sequences
   logic [7:0] kb_mods;
   logic [7:0] kb_keys [6];
   int         kb_count;

   int mismatches;
   int idle_cycles;
   bit no_idle;
   int stall_requests;
   int stall_served;
   int stall_left;

   usb_hid_report_to_ps2_scancodes_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   function automatic logic [15:0] set2_code(input logic [7:0] usage);
      if (usage < MAIN_END) begin
         return SET2_MAIN[usage];
      end else if (usage >= MOD_USAGE0 && usage <= MOD_USAGE0 + 8'd7) begin
         return SET2_MOD[usage[2:0]];
      end
      return 16'h0000;
   endfunction

   task automatic emit_code(input logic [7:0] usage, input bit is_break);
      logic [15:0] code;
      code = set2_code(usage);
      if (code != 16'h0000) begin
         if (code[15:8] != 8'h00) scan_bytes.push_back(code[15:8]);
         if (is_break) scan_bytes.push_back(SET2_BREAK);
         scan_bytes.push_back(code[7:0]);
      end
   endtask

   task automatic predict_report(input hid2ps2_pkg::req_type r);
      logic [7:0] slots [6];
      logic [7:0] kept [6];
      logic [7:0] fresh [6];
      logic [7:0] changed;
      int         nkept;
      int         nfresh;
      bit         rollover;
      bit         restart;
      bit         gone;
      bit         is_new;
      bit         stop;
      hid2ps2_pkg::rsp_type w;
      slots[0] = r.key_slot_0;
      slots[1] = r.key_slot_1;
      slots[2] = r.key_slot_2;
      slots[3] = r.key_slot_3;
      slots[4] = r.key_slot_4;
      slots[5] = r.key_slot_5;
      scan_bytes.delete();
      nkept = 0;
      nfresh = 0;
      rollover = 1'b0;
      restart = 1'b0;

      changed = r.modifier_bits ^ last_mods;
      for (int i = 0; i < 8; i++) begin
         if (changed[i]) emit_code(MOD_USAGE0 + 8'(i), !r.modifier_bits[i]);
      end
      last_mods = r.modifier_bits;

      for (int i = 0; i < 6; i++) begin
         if (slots[i] >= ROLLOVER_LO && slots[i] <= ROLLOVER_HI) rollover = 1'b1;
      end

      if (!rollover) begin
         // stored list is packed; first zero ends it
         stop = 1'b0;
         for (int i = 0; i < 6; i++) begin
            if (down_keys[i] == 8'h00) stop = 1'b1;
            if (!stop) begin
               gone = 1'b1;
               for (int j = 0; j < 6; j++) begin
                  if (down_keys[i] == slots[j]) gone = 1'b0;
               end
               if (gone) begin
                  emit_code(down_keys[i], 1'b1);
                  if (down_keys[i] == held_key_state) held_key_state = 8'h00;
               end
            end
         end

         for (int i = 0; i < 6; i++) kept[i] = 8'h00;
         for (int i = 0; i < 6; i++) begin
            if (slots[i] != 8'h00) begin
               kept[nkept] = slots[i];
               nkept++;
               is_new = 1'b1;
               stop = 1'b0;
               for (int j = 0; j < 6; j++) begin
                  if (down_keys[j] == 8'h00) stop = 1'b1;
                  if (!stop && down_keys[j] == slots[i]) is_new = 1'b0;
               end
               if (is_new) begin
                  fresh[nfresh] = slots[i];
                  nfresh++;
               end
            end
         end

         if (nfresh > 0) begin
            for (int i = 0; i < nfresh; i++) emit_code(fresh[i], 1'b0);
            held_key_state = fresh[nfresh - 1];
            restart = 1'b1;
         end
         for (int i = 0; i < 6; i++) down_keys[i] = kept[i];
      end

      w.held_key = held_key_state;
      w.repeat_restart = restart;
      if (scan_bytes.size() == 0) begin
         w.scan_byte = 8'h00;
         w.byte_valid = 1'b0;
         w.last_of_report = 1'b1;
         expected_words.push_back(w);
      end else begin
         for (int k = 0; k < scan_bytes.size(); k++) begin
            w.scan_byte = scan_bytes[k];
            w.byte_valid = 1'b1;
            w.last_of_report = (k == scan_bytes.size() - 1);
            expected_words.push_back(w);
         end
      end
   endtask

   function automatic hid2ps2_pkg::req_type make_report(input logic [7:0] mods,
                                           input logic [7:0] s0, input logic [7:0] s1,
                                           input logic [7:0] s2, input logic [7:0] s3,
                                           input logic [7:0] s4, input logic [7:0] s5);
      hid2ps2_pkg::req_type r;
      r.modifier_bits = mods;
      r.key_slot_0 = s0;
      r.key_slot_1 = s1;
      r.key_slot_2 = s2;
      r.key_slot_3 = s3;
      r.key_slot_4 = s4;
      r.key_slot_5 = s5;
      return r;
   endfunction

   task automatic send_report(input hid2ps2_pkg::req_type r);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_report(r);
   endtask

   function automatic logic [7:0] pick_usage();
      int c;
      c = $urandom_range(99);
      if (c < 60) return 8'($urandom_range(8'h65, 8'h04));
      if (c < 75) return 8'($urandom_range(8'h58, 8'h49));
      if (c < 85) return 8'($urandom_range(8'hE7, 8'hE0));
      return 8'($urandom_range(8'hFF, 8'h04));
   endfunction

   task automatic next_typing_report(output hid2ps2_pkg::req_type r);
      logic [7:0] s [6];
      logic [7:0] tmp;
      int         a;
      int         j;
      int         choice;
      if ($urandom_range(99) < 30) kb_mods ^= 8'(1 << $urandom_range(7));
      choice = $urandom_range(99);
      if (choice < 40 && kb_count < 6) begin
         kb_keys[kb_count] = pick_usage();
         kb_count++;
      end else if (choice < 75 && kb_count > 0) begin
         a = $urandom_range(kb_count - 1);
         for (int i = a; i < 5; i++) kb_keys[i] = kb_keys[i + 1];
         kb_count--;
      end else if (choice < 85 && kb_count > 0) begin
         kb_keys[$urandom_range(kb_count - 1)] = pick_usage();
      end else if (choice < 90) begin
         kb_count = 0;
      end
      for (int i = 0; i < 6; i++) s[i] = (i < kb_count) ? kb_keys[i] : 8'h00;
      if ($urandom_range(3) == 0) begin
         for (int i = 5; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = s[i];
            s[i] = s[j];
            s[j] = tmp;
         end
      end
      if (kb_count > 0 && $urandom_range(19) == 0) s[$urandom_range(5)] = kb_keys[0];
      r = make_report(kb_mods, s[0], s[1], s[2], s[3], s[4], s[5]);
   endtask

   task automatic next_random_report(output hid2ps2_pkg::req_type r);
      int c;
      int k;
      c = $urandom_range(99);
      next_typing_report(r);
      if (c >= 75 && c < 87) begin
         r = hid2ps2_pkg::req_type'(56'({$urandom, $urandom}));
      end else if (c >= 87 && c < 95) begin
         // rollover marker in one slot; slot k sits at bits 8*(5-k)
         k = $urandom_range(5);
         r[8 * (5 - k) +: 8] = 8'($urandom_range(ROLLOVER_HI, ROLLOVER_LO));
      end else if (c >= 95) begin
         r = make_report(kb_mods, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end
   endtask

   task automatic test_directed_reports();
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'hFF, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E));
      // every modifier and every stored key breaks, six extended makes: longest burst
      send_report(make_report(8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h54, 8'h58));
      send_report(make_report(8'h00, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h54, 8'h58));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // usages with no set-2 code
      send_report(make_report(8'h00, 8'h90, 8'hE3, 8'hFF, 8'hDF, 8'hE8, 8'h46));
      send_report(make_report(8'h22, 8'h04, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02));
      send_report(make_report(8'h00, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03, 8'h03));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h01, 8'h04, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h01, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'h01, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_report(make_report(8'h80, 8'hE0, 8'hE1, 8'hE2, 8'hE4, 8'hE5, 8'hE6));
      send_report(make_report(8'h7F, 8'h00, 8'h00, 8'h2A, 8'h00, 8'h39, 8'h00));
      send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_random_typing(input int count);
      hid2ps2_pkg::req_type r;
      for (int n = 0; n < count; n++) begin
         next_random_report(r);
         send_report(r);
      end
   endtask

   // result side holds off while reports keep coming, so the input stalls
   task automatic test_output_backpressure();
      hid2ps2_pkg::req_type r;
      @(negedge clock);
      stall_requests++;
      for (int n = 0; n < 10; n++) begin
         next_random_report(r);
         send_report(r);
      end
   endtask

   task automatic test_drain_pause();
      test_random_typing(8);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      test_random_typing(6);
   endtask

   task automatic test_no_idle_stretch();
      no_idle = 1'b1;
      test_random_typing(30);
      no_idle = 1'b0;
   endtask

   initial begin
      rsp_ready = 1'b0;
      stall_served = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (reset) begin
            rsp_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      hid2ps2_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word: byte %h valid %b last %b held %h restart %b",
                     $time, rsp_data.scan_byte, rsp_data.byte_valid,
                     rsp_data.last_of_report, rsp_data.held_key, rsp_data.repeat_restart);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.scan_byte !== want.scan_byte ||
                rsp_data.byte_valid !== want.byte_valid ||
                rsp_data.last_of_report !== want.last_of_report ||
                rsp_data.held_key !== want.held_key ||
                rsp_data.repeat_restart !== want.repeat_restart) begin
               mismatches++;
               $display("%0t: expected byte %h valid %b last %b held %h restart %b",
                        $time, want.scan_byte, want.byte_valid, want.last_of_report,
                        want.held_key, want.repeat_restart);
               $display("%0t: actual   byte %h valid %b last %b held %h restart %b",
                        $time, rsp_data.scan_byte, rsp_data.byte_valid,
                        rsp_data.last_of_report, rsp_data.held_key, rsp_data.repeat_restart);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** usb_hid_report_to_ps2_scancodes_core: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      no_idle = 1'b0;
      stall_requests = 0;
      mismatches = 0;
      idle_cycles = 0;
      last_mods = 8'h00;
      held_key_state = 8'h00;
      kb_mods = 8'h00;
      kb_count = 0;
      for (int i = 0; i < 6; i++) begin
         down_keys[i] = 8'h00;
         kb_keys[i] = 8'h00;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_reports();
      test_random_typing(100);
      test_output_backpressure();
      test_drain_pause();
      test_no_idle_stretch();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("** usb_hid_report_to_ps2_scancodes_core: PASSED **");
      end else begin
         $display("** usb_hid_report_to_ps2_scancodes_core: FAILED **");
      end
      $finish;
   end

endmodule
